[sv/hbs_pkg.sv]
// shared constants and types of the 3x3 height map box smoother
package hbs_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int AW        = $clog2(MAX_WIDTH);
  localparam int MAX_ROWS  = 1024;

  localparam int CFG_W       = 11;
  localparam int POS_W       = 10;
  localparam int Q8_W        = 16;
  localparam int SUM_W       = 12;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 40;

  localparam logic [CFG_W-1:0] FRAME_RESET = 11'd256;
  localparam logic [CFG_W-1:0] DIM_MIN     = 11'd2;
  localparam logic [CFG_W-1:0] WIDTH_MAX   = CFG_W'(MAX_WIDTH);
  localparam logic [CFG_W-1:0] HEIGHT_MAX  = CFG_W'(MAX_ROWS);
  localparam logic [Q8_W-1:0]  Q8_MAX      = 16'd65280;

  // register indexes
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // request kinds
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  // divisor selection
  localparam logic [1:0] DIV4 = 2'd0;
  localparam logic [1:0] DIV6 = 2'd1;
  localparam logic [1:0] DIV9 = 2'd2;

  // reciprocals scaled by 2^RECIP_SH, exact over the dividend range
  localparam int RECIP_SH = 24;
  localparam int DIVIDEND_W = 20;
  localparam int RECIP_W = 23;
  localparam logic [RECIP_W-1:0] RECIP3 = 23'd5592406;
  localparam logic [RECIP_W-1:0] RECIP9 = 23'd1864136;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef struct packed {
    logic                  last;
    logic [POS_W-1:0]      col;
    logic [POS_W-1:0]      row;
    logic [Q8_W-1:0]       height;
  } res_t;

endpackage

[sv/heightmap_box_smoother_3x3_top.sv]
// 3x3 box smoother over a streamed height map with border renormalisation
// path: stage 1, stage 2 and the result queue lie between the request that completes a window
//   and its result; results trail the input by one row plus one sample (W + 1 requests)
// throughput: one request per clock while the result queue has room, set by the one-per-cycle
//   read-modify-write of the line store memory and a four-entry result queue
// reset: rst_n synchronous, clears counters, window, pipeline and queue; sizes
//   return to 256 x 256; line store contents are kept (border taps mask them)
module heightmap_box_smoother_3x3_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [hbs_pkg::IN_TDATA_W-1:0]    in_tdata,   // sample[7:0]
  input  logic                              in_tuser,   // op[0]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [hbs_pkg::OUT_TDATA_W-1:0]   out_tdata,  // height_q8[15:0], out_row[25:16],
                                                        // out_col[35:26], zero[39:36]
  output logic                              out_tlast,  // frame_last
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [hbs_pkg::CFG_W-1:0]         cfg_wdata
);
  import hbs_pkg::*;

  // configuration
  logic [CFG_W-1:0] fw_r, fh_r, w_use, h_use;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= FRAME_RESET;
      fh_r <= FRAME_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  fw_r <= cfg_wdata;
        REG_FRAME_HEIGHT: fh_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    w_use = fw_r;
    if (fw_r < DIM_MIN) w_use = DIM_MIN;
    if (fw_r > WIDTH_MAX) w_use = WIDTH_MAX;
    h_use = fh_r;
    if (fh_r < DIM_MIN) h_use = DIM_MIN;
    if (fh_r > HEIGHT_MAX) h_use = HEIGHT_MAX;
  end

  // position counters
  logic [CFG_W-1:0] in_row_r, in_row_nxt;
  logic [AW-1:0]    in_col_r, in_col_nxt;
  logic [POS_W-1:0] em_row_r, em_row_nxt, em_col_r, em_col_nxt;

  logic acc, active, emit0, last0, flushing;
  logic col_lo0, col_hi0, row_lo0, row_hi0;
  logic [IN_TDATA_W-1:0] s0;

  assign acc      = in_tvalid && in_tready;
  assign flushing = (in_row_r >= h_use);
  assign active   = flushing || (in_tuser == OP_SAMPLE);
  assign emit0    = (in_row_r >= CFG_W'(2)) || ((in_row_r == CFG_W'(1)) && (in_col_r != '0));
  assign last0    = emit0 && ({1'b0, em_row_r} == h_use - CFG_W'(1))
                          && ({1'b0, em_col_r} == w_use - CFG_W'(1));
  assign s0       = flushing ? '0 : in_tdata;

  // border taps of the result being formed
  assign col_lo0 = (em_col_r != '0);
  assign col_hi0 = ({1'b0, em_col_r} + CFG_W'(1)) < w_use;
  assign row_lo0 = (em_row_r != '0);
  assign row_hi0 = ({1'b0, em_row_r} + CFG_W'(1)) < h_use;

  always_comb begin
    in_row_nxt = in_row_r;
    in_col_nxt = in_col_r;
    em_row_nxt = em_row_r;
    em_col_nxt = em_col_r;
    if (cfg_we) begin
      in_row_nxt = '0;
      in_col_nxt = '0;
      em_row_nxt = '0;
      em_col_nxt = '0;
    end else if (acc && active) begin
      if (({1'b0, in_col_r} + CFG_W'(1)) >= w_use) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + CFG_W'(1);
      end else begin
        in_col_nxt = in_col_r + AW'(1);
      end
      if (last0) begin
        in_row_nxt = '0;
        in_col_nxt = '0;
        em_row_nxt = '0;
        em_col_nxt = '0;
      end else if (emit0) begin
        if (({1'b0, em_col_r} + CFG_W'(1)) >= w_use) begin
          em_col_nxt = '0;
          em_row_nxt = em_row_r + POS_W'(1);
        end else begin
          em_col_nxt = em_col_r + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_row_r <= '0;
      in_col_r <= '0;
      em_row_r <= '0;
      em_col_r <= '0;
    end else begin
      in_row_r <= in_row_nxt;
      in_col_r <= in_col_nxt;
      em_row_r <= em_row_nxt;
      em_col_r <= em_col_nxt;
    end
  end

  // line stores: entry holds {two rows up, one row up}
  logic [2*IN_TDATA_W-1:0] line_mem [MAX_WIDTH];
  logic [2*IN_TDATA_W-1:0] rd_r;

  // stage 1: memory data back, window shift, tap sum
  logic                  s1_v_r, s1_e_r;
  logic [IN_TDATA_W-1:0] s1_s_r;
  logic [AW-1:0]         s1_idx_r;
  logic [POS_W-1:0]      s1_row_r, s1_col_r;
  logic                  s1_last_r;
  logic [2:0]            s1_cm_r, s1_rm_r;

  always_ff @(posedge clk) begin
    if (acc && active) rd_r <= line_mem[in_col_r];
    // read and write addresses differ since the width is at least two, except
    // for the first request of a new frame, whose stale rows are border taps
    if (s1_v_r) line_mem[s1_idx_r] <= {rd_r[IN_TDATA_W-1:0], s1_s_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s1_e_r <= 1'b0;
    end else begin
      s1_v_r <= acc && active && !cfg_we;
      s1_e_r <= emit0;
    end
    s1_s_r    <= s0;
    s1_idx_r  <= in_col_r;
    s1_row_r  <= em_row_r;
    s1_col_r  <= em_col_r;
    s1_last_r <= last0;
    s1_cm_r   <= {col_hi0, 1'b1, col_lo0};
    s1_rm_r   <= {row_hi0, 1'b1, row_lo0};
  end

  // window, index column * 3 + row, column 2 newest
  logic [IN_TDATA_W-1:0] win_r [9];
  logic [IN_TDATA_W-1:0] sh [9];
  logic [SUM_W-1:0]      sum1;
  logic [1:0]            div1;

  always_comb begin
    for (int p = 0; p < 6; p++) sh[p] = win_r[p+3];
    sh[6] = rd_r[2*IN_TDATA_W-1:IN_TDATA_W];
    sh[7] = rd_r[IN_TDATA_W-1:0];
    sh[8] = s1_s_r;
    sum1 = '0;
    for (int p = 0; p < 3; p++) begin
      for (int q = 0; q < 3; q++) begin
        if (s1_cm_r[p] && s1_rm_r[q]) sum1 = sum1 + SUM_W'(sh[p*3+q]);
      end
    end
    if (s1_cm_r[0] && s1_cm_r[2] && s1_rm_r[0] && s1_rm_r[2]) div1 = DIV9;
    else if ((s1_cm_r[0] && s1_cm_r[2]) || (s1_rm_r[0] && s1_rm_r[2])) div1 = DIV6;
    else div1 = DIV4;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      for (int p = 0; p < 9; p++) win_r[p] <= '0;
    end else if (s1_v_r) begin
      for (int p = 0; p < 9; p++) win_r[p] <= (s1_e_r && s1_last_r) ? '0 : sh[p];
    end
  end

  // stage 2: constant divide by reciprocal multiply, or by shift for the divisor four
  logic                  s2_e_r;
  logic [SUM_W-1:0]      s2_sum_r;
  logic [1:0]            s2_div_r;
  logic [POS_W-1:0]      s2_row_r, s2_col_r;
  logic                  s2_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_e_r <= 1'b0;
    end else begin
      s2_e_r <= s1_v_r && s1_e_r;
    end
    s2_sum_r  <= sum1;
    s2_div_r  <= div1;
    s2_row_r  <= s1_row_r;
    s2_col_r  <= s1_col_r;
    s2_last_r <= s1_last_r;
  end

  logic [DIVIDEND_W-1:0]          dvd;
  logic [RECIP_W-1:0]             recip;
  logic [DIVIDEND_W+RECIP_W-1:0]  prod;
  logic [Q8_W-1:0]                q2;
  res_t                           res2;

  always_comb begin
    // (256 sum + n/2) / n, with n = 6 folded to (128 sum + 1) / 3
    dvd   = DIVIDEND_W'({s2_sum_r, 8'd0}) + DIVIDEND_W'(4);
    recip = RECIP9;
    case (s2_div_r)
      DIV6: begin
        dvd   = DIVIDEND_W'({s2_sum_r, 7'd0}) + DIVIDEND_W'(1);
        recip = RECIP3;
      end
      default: ;
    endcase
    prod = (DIVIDEND_W+RECIP_W)'(dvd) * (DIVIDEND_W+RECIP_W)'(recip);
    if (s2_div_r == DIV4) q2 = Q8_W'({s2_sum_r, 6'd0});
    else q2 = prod[RECIP_SH+Q8_W-1:RECIP_SH];
    res2.height = q2;
    res2.row    = s2_row_r;
    res2.col    = s2_col_r;
    res2.last   = s2_last_r;
  end

  // result queue, with room kept for everything in flight
  res_t               fifo_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]   cnt_r, cnt_nxt;
  logic [FIFO_AW+1:0] credit;
  logic               push, pop;
  res_t               head;

  assign push   = s2_e_r;
  assign pop    = out_tvalid && out_tready;
  assign credit = (FIFO_AW+2)'(cnt_r) + (FIFO_AW+2)'(s1_v_r && s1_e_r)
                + (FIFO_AW+2)'(s2_e_r);
  assign in_tready = credit < (FIFO_AW+2)'(FIFO_DEPTH);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + (FIFO_AW+1)'(1);
    else if (pop && !push) cnt_nxt = cnt_r - (FIFO_AW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      if (pop) rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      cnt_r <= cnt_nxt;
    end
    if (push) fifo_r[wr_ptr_r] <= res2;
  end

  assign head       = fifo_r[rd_ptr_r];
  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = {4'd0, head.col, head.row, head.height};
  assign out_tlast  = head.last;

endmodule

[sv/hbs_checker.sv]
// port-level checks of the 3x3 height map box smoother, bound to the top level
module hbs_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [hbs_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tlast
);
  import hbs_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // a mean of bytes never exceeds 255.0
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[15:0] <= Q8_MAX)
    else $error("smoothed height out of range");

  // frames are at least two by two, so the final sample is never on row or column zero
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[25:16] != '0 && out_tdata[35:26] != '0)
    else $error("frame end at an impossible position");

endmodule

bind heightmap_box_smoother_3x3_top hbs_checker u_hbs_checker (.*);

[tb/tb_top.sv]
// self-checking testbench for the 3x3 height map box smoother
module tb_top;
  import hbs_pkg::*;

  localparam int HOLD_CYCLES  = 400;
  localparam int STALL_LIMIT  = 4000;
  localparam int SETTLE       = 8;
  localparam int RANDOM_ITEMS = 420;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tuser   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_we     = 1'b0;
  logic                   cfg_index  = 1'b0;
  logic [CFG_W-1:0]       cfg_wdata  = '0;

  heightmap_box_smoother_3x3_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // sample[7:0]
    .in_tuser   (in_tuser),   // op[0]
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // height_q8[15:0], out_row[25:16], out_col[35:26], zero[39:36]
    .out_tlast  (out_tlast),  // frame_last
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // smoother state as seen from outside
  logic [CFG_W-1:0] sm_width;
  logic [CFG_W-1:0] sm_height;
  logic [7:0]       sm_line_prev  [MAX_WIDTH];
  logic [7:0]       sm_line_prev2 [MAX_WIDTH];
  logic [7:0]       sm_win        [9];
  int unsigned      sm_in_row, sm_in_col, sm_out_row, sm_out_col;

  res_t smoothed_q[$];
  int   fed_cnt  = 0;
  int   err_cnt  = 0;
  int   quiet_cycles = 0;
  bit   src_idle  = 1'b1;
  bit   sink_idle = 1'b1;
  bit   hold_req  = 1'b0;

  function automatic int unsigned eff_dim(input logic [CFG_W-1:0] v,
                                          input logic [CFG_W-1:0] hi);
    if (v < DIM_MIN) return DIM_MIN;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void sm_restart();
    sm_in_row  = 0;
    sm_in_col  = 0;
    sm_out_row = 0;
    sm_out_col = 0;
    for (int p = 0; p < 9; p++) sm_win[p] = 8'd0;
  endfunction

  // queues a predicted result behind the ones already waiting
  function automatic void note_result(input res_t r);
    smoothed_q.insert(smoothed_q.size(), r);
  endfunction

  // advances the smoother by one accepted request; returns 1 when a result is due
  function automatic bit smooth_step(input logic op, input logic [7:0] smp,
                                     output res_t res);
    int unsigned w, h, sum, cnt;
    int          c, r;
    logic [7:0]  s;
    bit          fires;
    w   = eff_dim(sm_width, WIDTH_MAX);
    h   = eff_dim(sm_height, HEIGHT_MAX);
    s   = smp;
    res = '0;
    if (sm_in_row < h) begin
      if (op == OP_FLUSH) return 1'b0;
    end else begin
      // past the last row every request is a flush tick
      s = 8'd0;
    end
    fed_cnt++;
    for (int p = 0; p < 6; p++) sm_win[p] = sm_win[p+3];
    sm_win[6] = sm_line_prev2[sm_in_col];
    sm_win[7] = sm_line_prev[sm_in_col];
    sm_win[8] = s;
    sm_line_prev2[sm_in_col] = sm_line_prev[sm_in_col];
    sm_line_prev[sm_in_col]  = s;
    fires = (sm_in_row >= 2) || (sm_in_row == 1 && sm_in_col >= 1);
    sm_in_col++;
    if (sm_in_col >= w) begin
      sm_in_col = 0;
      sm_in_row++;
    end
    if (!fires) return 1'b0;
    sum = 0;
    cnt = 0;
    for (int p = 0; p < 3; p++) begin
      c = int'(sm_out_col) + p - 1;
      if (c < 0 || c >= int'(w)) continue;
      for (int q = 0; q < 3; q++) begin
        r = int'(sm_out_row) + q - 1;
        if (r < 0 || r >= int'(h)) continue;
        sum += sm_win[p*3+q];
        cnt++;
      end
    end
    res.height = Q8_W'((sum * 256 + cnt / 2) / cnt);
    res.row    = POS_W'(sm_out_row);
    res.col    = POS_W'(sm_out_col);
    res.last   = (sm_out_row == h - 1) && (sm_out_col == w - 1);
    if (res.last) begin
      sm_restart();
    end else begin
      sm_out_col++;
      if (sm_out_col >= w) begin
        sm_out_col = 0;
        sm_out_row++;
      end
    end
    return 1'b1;
  endfunction

  task automatic send_request(input logic op, input logic [7:0] smp);
    int   gap;
    res_t res;
    gap = src_idle ? $urandom_range(0, 10) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= smp;
    do @(posedge clk); while (!in_tready);
    if (smooth_step(op, smp, res)) note_result(res);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (smoothed_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic [CFG_W-1:0] val);
    drain_results();
    // requests that give no result may still be in the pipeline
    repeat (SETTLE) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_FRAME_WIDTH) sm_width = val;
    else sm_height = val;
    sm_restart();
  endtask

  // one frame of random heights; cut_at ends it early, pause_at waits for the results
  task automatic feed_frame(input int w, input int h, input int cut_at, input int pause_at);
    for (int i = 0; i < w * h; i++) begin
      if (i == cut_at) return;
      if (i == pause_at) drain_results();
      if ($urandom_range(0, 15) == 0) send_request(OP_FLUSH, 8'($urandom));
      send_request(OP_SAMPLE, 8'($urandom));
    end
    for (int i = 0; i <= w; i++)
      send_request(($urandom_range(0, 3) == 0) ? OP_SAMPLE : OP_FLUSH, 8'($urandom));
  endtask

  task automatic test_directed();
    write_cfg(REG_FRAME_WIDTH, 11'd3);
    write_cfg(REG_FRAME_HEIGHT, 11'd3);
    // flush with nothing pending is ignored
    send_request(OP_FLUSH, 8'hA5);
    repeat (9) send_request(OP_SAMPLE, 8'hFF);
    // a sample past the frame counts as a flush tick
    send_request(OP_SAMPLE, 8'h5A);
    repeat (3) send_request(OP_FLUSH, 8'h00);
    send_request(OP_FLUSH, 8'h00);
    write_cfg(REG_FRAME_WIDTH, 11'd2);
    write_cfg(REG_FRAME_HEIGHT, 11'd2);
    send_request(OP_SAMPLE, 8'h00);
    send_request(OP_SAMPLE, 8'hFF);
    send_request(OP_SAMPLE, 8'h80);
    send_request(OP_SAMPLE, 8'h01);
    repeat (3) send_request(OP_FLUSH, 8'h00);
  endtask

  task automatic test_size_extremes();
    // oversized height: only the first rows are fed before the frame is cut
    write_cfg(REG_FRAME_WIDTH, 11'd0);
    write_cfg(REG_FRAME_HEIGHT, 11'd2047);
    feed_frame(2, 1024, 64, -1);
    write_cfg(REG_FRAME_WIDTH, 11'd3);
    write_cfg(REG_FRAME_HEIGHT, 11'd1);
    feed_frame(3, 2, -1, -1);
    write_cfg(REG_FRAME_WIDTH, 11'd1);
    write_cfg(REG_FRAME_HEIGHT, 11'd0);
    feed_frame(2, 2, -1, -1);
  endtask

  task automatic test_restart_mid_frame();
    write_cfg(REG_FRAME_WIDTH, 11'd5);
    write_cfg(REG_FRAME_HEIGHT, 11'd4);
    feed_frame(5, 4, 12, -1);
    write_cfg(REG_FRAME_HEIGHT, 11'd4);
    feed_frame(5, 4, -1, -1);
  endtask

  task automatic test_backpressure();
    write_cfg(REG_FRAME_WIDTH, 11'd16);
    write_cfg(REG_FRAME_HEIGHT, 11'd4);
    src_idle = 1'b0;
    hold_req = 1'b1;
    feed_frame(16, 4, -1, -1);
    src_idle = 1'b1;
  endtask

  task automatic test_sender_pause();
    write_cfg(REG_FRAME_WIDTH, 11'd7);
    write_cfg(REG_FRAME_HEIGHT, 11'd5);
    feed_frame(7, 5, -1, 17);
  endtask

  task automatic test_random_frames();
    int start, w, h, cut, pause;
    start = fed_cnt;
    while (fed_cnt - start < RANDOM_ITEMS) begin
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 64) : $urandom_range(2, 10);
      h = $urandom_range(2, 6);
      cut   = ($urandom_range(0, 7) == 0) ? $urandom_range(1, w * h - 1) : -1;
      pause = ($urandom_range(0, 9) == 0) ? $urandom_range(1, w * h - 1) : -1;
      write_cfg(REG_FRAME_WIDTH, CFG_W'(w));
      write_cfg(REG_FRAME_HEIGHT, CFG_W'(h));
      src_idle  = ($urandom_range(0, 3) != 0);
      sink_idle = ($urandom_range(0, 3) != 0);
      feed_frame(w, h, cut, pause);
    end
    src_idle  = 1'b1;
    sink_idle = 1'b1;
  endtask

  initial begin
    sm_width  = FRAME_RESET;
    sm_height = FRAME_RESET;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      sm_line_prev[i]  = 8'd0;
      sm_line_prev2[i] = 8'd0;
    end
    sm_restart();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_size_extremes();
    test_restart_mid_frame();
    test_backpressure();
    test_sender_pause();
    test_random_frames();
    drain_results();
    repeat (20) @(posedge clk);
    if (err_cnt == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  // result side: random stalls, one long hold-off on request
  initial begin : result_sink
    int   gap;
    res_t want;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      gap = sink_idle ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      if (smoothed_q.size() == 0) begin
        $error("unexpected result at row %0d col %0d",
               out_tdata[Q8_W +: POS_W], out_tdata[Q8_W+POS_W +: POS_W]);
        err_cnt++;
      end else begin
        want = smoothed_q.pop_front();
        if (out_tdata[Q8_W-1:0] !== want.height) begin
          $error("height_q8: expected %0d, got %0d", want.height, out_tdata[Q8_W-1:0]);
          err_cnt++;
        end
        if (out_tdata[Q8_W +: POS_W] !== want.row) begin
          $error("out_row: expected %0d, got %0d", want.row, out_tdata[Q8_W +: POS_W]);
          err_cnt++;
        end
        if (out_tdata[Q8_W+POS_W +: POS_W] !== want.col) begin
          $error("out_col: expected %0d, got %0d", want.col, out_tdata[Q8_W+POS_W +: POS_W]);
          err_cnt++;
        end
        if (out_tlast !== want.last) begin
          $error("frame_last: expected %0d, got %0d", want.last, out_tlast);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

endmodule
